// File: hw/rtl/kvct_pkg.sv
package kvct_pkg;

  // Text limits. Offsets and lengths are reported modulo 2^16.
  localparam longint unsigned MaxTextBytes = 65536;
  localparam int unsigned PosW = $clog2(MaxTextBytes + 1);
  localparam logic [PosW-1:0] PosLimit = PosW'(MaxTextBytes);
  localparam int unsigned FieldW = 16;

  // Result queue and per-item result budget.
  localparam int unsigned ResultDepth = 8;
  localparam int unsigned ResultPtrW = $clog2(ResultDepth);
  localparam int unsigned ResultCntW = $clog2(ResultDepth + 1);
  localparam int unsigned MaxPerStep = 4;
  localparam int unsigned StepCntW = $clog2(MaxPerStep + 1);
  localparam int unsigned StepIdxW = $clog2(MaxPerStep);

  localparam int unsigned OutDataW = 80;

  // Characters of interest.
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharDig0   = 8'h30;
  localparam logic [7:0] CharDig9   = 8'h39;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharLoA    = 8'h61;
  localparam logic [7:0] CharLoZ    = 8'h7A;

  typedef enum logic {
    KindByte = 1'b0,
    KindEnd  = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    ModeSpace   = 2'd0,
    ModeComment = 2'd1,
    ModeIdent   = 2'd2,
    ModeString  = 2'd3
  } lex_mode_e;

  typedef enum logic [2:0] {
    TokIdent   = 3'd0,
    TokEqual   = 3'd1,
    TokString  = 3'd2,
    TokEnd     = 3'd3,
    TokInvalid = 3'd4
  } tok_kind_e;

  typedef enum logic [2:0] {
    EvPair       = 3'd0,
    EvUnterm     = 3'd1,
    EvBadChar    = 3'd2,
    EvUnexpected = 3'd3,
    EvDone       = 3'd4
  } event_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [FieldW-1:0] off;
    logic [FieldW-1:0] len;
  } tok_t;

  typedef struct packed {
    event_e            ev;
    logic [FieldW-1:0] key_off;
    logic [FieldW-1:0] key_len;
    logic [FieldW-1:0] text_off;
    logic [FieldW-1:0] text_len;
    tok_kind_e         tkind;
    logic [7:0]        bad;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } out_item_t;

  typedef struct packed {
    lex_mode_e         mode;
    logic              quote_single;
    logic [FieldW-1:0] tok_start;
    logic [FieldW-1:0] tok_len;
    logic [PosW-1:0]   pos;
    logic              finished;
  } lex_state_t;

  // Lexer actions for one item, applied by the parser in this order:
  // pre event, first token, middle event, second token, close.
  typedef struct packed {
    logic    pre_valid;
    result_t pre;
    logic    push_a_valid;
    tok_t    push_a;
    logic    mid_valid;
    result_t mid;
    logic    push_b_valid;
    tok_t    push_b;
    logic    close;
  } lex_act_t;

  typedef struct packed {
    logic [1:0]    count;
    tok_t [1:0]    tok;
  } held_t;

  typedef struct packed {
    logic [StepCntW-1:0]             count;
    result_t [MaxPerStep-1:0]        res;
    logic                            pend_valid;
    result_t                         pend;
  } collect_t;

  localparam tok_t EndTok = '{kind: TokEnd, off: '0, len: '0};

  localparam result_t NullResult = '{
    ev: EvPair, key_off: '0, key_len: '0, text_off: '0, text_len: '0,
    tkind: TokIdent, bad: '0
  };

  localparam lex_state_t LexReset = '{
    mode: ModeSpace, quote_single: 1'b0, tok_start: '0, tok_len: '0,
    pos: '0, finished: 1'b0
  };

  localparam held_t HeldReset = '{count: 2'd0, tok: '{EndTok, EndTok}};

endpackage

// File: hw/rtl/kvct_lexer.sv
module kvct_lexer import kvct_pkg::*; (
  input  item_kind_e item_kind_i,
  input  logic [7:0] item_byte_i,
  input  lex_state_t state_i,
  output lex_state_t state_o,
  output lex_act_t   act_o
);

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[CharUpA:CharUpZ], [CharLoA:CharLoZ]};
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return c inside {[CharUpA:CharUpZ], [CharLoA:CharLoZ], [CharDig0:CharDig9],
                     CharUnder, CharDot};
  endfunction

  logic       fall;
  logic       do_close;
  logic [7:0] quote;

  always_comb begin
    state_o  = state_i;
    act_o    = '0;
    act_o.pre  = NullResult;
    act_o.mid  = NullResult;
    act_o.push_a = EndTok;
    act_o.push_b = EndTok;
    fall     = 1'b0;
    do_close = 1'b0;
    quote    = state_i.quote_single ? CharSquote : CharDquote;

    if (item_kind_i == KindEnd) begin
      do_close = !state_i.finished;
      state_o  = LexReset;
    end else if (!state_i.finished) begin
      if (item_byte_i == CharNul || state_i.pos >= PosLimit) begin
        do_close          = 1'b1;
        state_o.mode      = ModeSpace;
        state_o.finished  = 1'b1;
      end else begin
        state_o.pos = state_i.pos + 1'b1;
        case (state_i.mode)
          ModeIdent: begin
            if (is_ident_char(item_byte_i)) begin
              state_o.tok_len = state_i.tok_len + 1'b1;
            end else begin
              act_o.push_a_valid = 1'b1;
              act_o.push_a = '{kind: TokIdent, off: state_i.tok_start, len: state_i.tok_len};
              state_o.mode = ModeSpace;
              fall = 1'b1;
            end
          end
          ModeString: begin
            if (item_byte_i == quote) begin
              act_o.push_a_valid = 1'b1;
              act_o.push_a = '{kind: TokString, off: state_i.tok_start, len: state_i.tok_len};
              state_o.mode = ModeSpace;
            end else begin
              state_o.tok_len = state_i.tok_len + 1'b1;
            end
          end
          ModeComment: begin
            if (item_byte_i == CharLf) begin
              state_o.mode = ModeSpace;
            end
          end
          default: begin
            fall = 1'b1;
          end
        endcase

        if (fall) begin
          if (item_byte_i inside {CharSpace, CharTab, CharCr, CharLf}) begin
            // Whitespace between tokens is skipped.
          end else if (item_byte_i == CharHash) begin
            state_o.mode = ModeComment;
          end else if (item_byte_i == CharEq) begin
            act_o.push_b_valid = 1'b1;
            act_o.push_b = '{kind: TokEqual, off: '0, len: '0};
          end else if (item_byte_i == CharDquote || item_byte_i == CharSquote) begin
            state_o.mode         = ModeString;
            state_o.quote_single = (item_byte_i == CharSquote);
            state_o.tok_start    = FieldW'(state_i.pos) + 1'b1;
            state_o.tok_len      = '0;
          end else if (is_letter(item_byte_i)) begin
            state_o.mode      = ModeIdent;
            state_o.tok_start = FieldW'(state_i.pos);
            state_o.tok_len   = FieldW'(1);
          end else begin
            act_o.mid_valid     = 1'b1;
            act_o.mid.ev        = EvBadChar;
            act_o.mid.text_off  = FieldW'(state_i.pos);
            act_o.mid.bad       = item_byte_i;
            act_o.push_b_valid  = 1'b1;
            act_o.push_b = '{kind: TokInvalid, off: '0, len: '0};
          end
        end
      end
    end

    if (do_close) begin
      act_o.close = 1'b1;
      case (state_i.mode)
        ModeIdent: begin
          act_o.push_a_valid = 1'b1;
          act_o.push_a = '{kind: TokIdent, off: state_i.tok_start, len: state_i.tok_len};
        end
        ModeString: begin
          act_o.pre_valid    = 1'b1;
          act_o.pre.ev       = EvUnterm;
          act_o.pre.text_off = state_i.tok_start;
          act_o.pre.text_len = state_i.tok_len;
          act_o.push_a_valid = 1'b1;
          act_o.push_a = '{kind: TokString, off: state_i.tok_start, len: state_i.tok_len};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/kvct_parser.sv
module kvct_parser import kvct_pkg::*; (
  input  held_t    held_i,
  input  logic     pend_valid_i,
  input  result_t  pend_i,
  input  lex_act_t act_i,
  output held_t    held_o,
  output collect_t collect_o
);

  localparam int unsigned NumSlots = 7;
  localparam int unsigned NumList  = NumSlots + 1;
  localparam int unsigned ListCntW = $clog2(NumList + 1);

  typedef struct packed {
    tok_t [2:0] win;
    logic [1:0] n;
    result_t    ev;
  } parse_t;

  function automatic parse_t push_tok(parse_t p, tok_t tok);
    parse_t r;
    r = p;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) == p.n) begin
        r.win[i] = tok;
      end
    end
    r.n = p.n + 2'd1;
    return r;
  endfunction

  // One parser decision on a three-token window; missing tokens read as end.
  function automatic parse_t decide(parse_t p);
    parse_t     r;
    logic [1:0] d;
    logic [1:0] drop;
    tok_t       t;
    r    = p;
    r.ev = NullResult;
    d    = 2'd0;
    if (p.win[0].kind == TokIdent && p.win[1].kind == TokEqual &&
        p.win[2].kind == TokString) begin
      r.ev.ev       = EvPair;
      r.ev.key_off  = p.win[0].off;
      r.ev.key_len  = p.win[0].len;
      r.ev.text_off = p.win[2].off;
      r.ev.text_len = p.win[2].len;
      drop = 2'd3;
    end else begin
      if (p.win[0].kind == TokIdent) begin
        d = (p.win[1].kind == TokEqual) ? 2'd2 : 2'd1;
      end
      t = p.win[d];
      r.ev.ev    = EvUnexpected;
      r.ev.tkind = t.kind;
      if (t.kind == TokIdent || t.kind == TokString) begin
        r.ev.text_off = t.off;
        r.ev.text_len = t.len;
      end
      drop = d + 2'd1;
    end
    for (int i = 0; i < 3; i++) begin
      if (i + int'(drop) < 3) begin
        r.win[i] = p.win[i + int'(drop)];
      end else begin
        r.win[i] = EndTok;
      end
    end
    r.n = (p.n > drop) ? p.n - drop : 2'd0;
    return r;
  endfunction

  parse_t                st;
  result_t               slot [NumSlots];
  logic [NumSlots-1:0]   slot_v;
  result_t               list [NumList];
  logic [NumList-1:0]    list_v;
  logic [ListCntW-1:0]   idx;

  always_comb begin
    st.ev     = NullResult;
    st.n      = held_i.count;
    st.win[0] = (held_i.count > 2'd0) ? held_i.tok[0] : EndTok;
    st.win[1] = (held_i.count > 2'd1) ? held_i.tok[1] : EndTok;
    st.win[2] = EndTok;

    for (int i = 0; i < NumSlots; i++) begin
      slot[i] = NullResult;
    end
    slot_v = '0;

    slot[0]   = act_i.pre;
    slot_v[0] = act_i.pre_valid;

    if (act_i.push_a_valid) begin
      st = push_tok(st, act_i.push_a);
      if (st.n == 2'd3) begin
        st        = decide(st);
        slot[1]   = st.ev;
        slot_v[1] = 1'b1;
      end
    end

    slot[2]   = act_i.mid;
    slot_v[2] = act_i.mid_valid;

    if (act_i.push_b_valid) begin
      st = push_tok(st, act_i.push_b);
      if (st.n == 2'd3) begin
        st        = decide(st);
        slot[3]   = st.ev;
        slot_v[3] = 1'b1;
      end
    end

    // At the close every held token is decided, missing ones counting as end.
    for (int k = 0; k < 2; k++) begin
      if (act_i.close && st.n != 2'd0) begin
        st          = decide(st);
        slot[4 + k] = st.ev;
        slot_v[4 + k] = 1'b1;
      end
    end

    slot[6].ev = EvDone;
    slot_v[6]  = act_i.close;

    held_o.count  = st.n;
    held_o.tok[0] = st.win[0];
    held_o.tok[1] = st.win[1];

    // A result held back from the previous item goes out first.
    list[0]   = pend_i;
    list_v[0] = pend_valid_i;
    for (int i = 0; i < NumSlots; i++) begin
      list[i + 1]   = slot[i];
      list_v[i + 1] = slot_v[i];
    end

    collect_o            = '0;
    collect_o.pend       = NullResult;
    for (int i = 0; i < MaxPerStep; i++) begin
      collect_o.res[i] = NullResult;
    end
    idx = '0;
    for (int e = 0; e < NumList; e++) begin
      if (list_v[e]) begin
        if (idx < ListCntW'(MaxPerStep)) begin
          collect_o.res[idx[StepIdxW-1:0]] = list[e];
        end else if (idx == ListCntW'(MaxPerStep)) begin
          collect_o.pend_valid = 1'b1;
          collect_o.pend       = list[e];
        end
        idx = idx + 1'b1;
      end
    end
    collect_o.count = (idx > ListCntW'(MaxPerStep)) ? StepCntW'(MaxPerStep)
                                                    : StepCntW'(idx);
  end

endmodule

// File: hw/rtl/kvct_result_fifo.sv
module kvct_result_fifo import kvct_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [StepCntW-1:0]      wr_count_i,
  input  result_t [MaxPerStep-1:0] wr_data_i,
  output logic                     space_ok_o,
  output logic                     rd_valid_o,
  input  logic                     rd_ready_i,
  output out_item_t                rd_data_o
);

  out_item_t             mem_q [ResultDepth];
  logic [ResultPtrW-1:0] wptr_q, wptr_d;
  logic [ResultPtrW-1:0] rptr_q, rptr_d;
  logic [ResultCntW-1:0] count_q, count_d;
  logic [ResultPtrW-1:0] wr_idx [MaxPerStep];
  logic [StepCntW-1:0]   wr_num;
  logic                  pop;

  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign space_ok_o = (count_q <= ResultCntW'(ResultDepth - MaxPerStep));
  assign pop        = rd_valid_o && rd_ready_i;
  assign wr_num     = wr_en_i ? wr_count_i : '0;

  always_comb begin
    for (int i = 0; i < MaxPerStep; i++) begin
      wr_idx[i] = wptr_q + ResultPtrW'(i);
    end
    wptr_d  = wptr_q + ResultPtrW'(wr_num);
    rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + ResultCntW'(wr_num) - ResultCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // The final result written for an item carries the last flag.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPerStep; i++) begin
      if (StepCntW'(i) < wr_num) begin
        mem_q[wr_idx[i]].res  <= wr_data_i[i];
        mem_q[wr_idx[i]].last <= (StepCntW'(i + 1) == wr_num);
      end
    end
  end

endmodule

// File: hw/rtl/key_value_config_tokenizer_unit.sv
// Key/value configuration tokenizer. The block takes a configuration text one
// byte per item on the slave stream and reports, on the master stream, every
// key = "value" pair as byte offsets and lengths, together with errors for
// unterminated strings, unrecognised characters and unexpected tokens, and a
// done result when the text closes (on a NUL byte, on the byte at offset
// 65536, or on an end item, which also rearms the block for a new text at
// offset zero). Spaces, tabs, CR, LF and '#' comments are skipped; strings may
// use single or double quotes; identifiers start with a letter and continue
// with letters, digits, '_' or '.'. Offsets and lengths are given modulo 2^16.
// Each accepted item is held in an input register, lexed and parsed by short
// combinational logic, and its results are written from that register into
// an eight-entry result queue that feeds the master stream. The block
// accepts one item per clock cycle and delivers one result per cycle while
// m_axis_tready is high; it stalls its input only while the result queue
// holds more than four results, which is set by the worst case of four
// results per item. An item gives at most four results,
// the final one marked with tlast. A close that ends an unterminated string
// can give five: the fifth is held inside the block and delivered at the head
// of the results of the next accepted item, so a user who needs it should
// follow the close with a further item (an end item does this harmlessly).
// There is no clearing pass after reset.
module key_value_config_tokenizer_unit import kvct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] text_byte
  input  logic                s_axis_tuser,  // [0] kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] key_offset, [31:16] key_length, [47:32] text_offset,
  // [63:48] text_length, [66:64] token_kind, [74:67] bad_char, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser,  // [2:0] event_res
  output logic                m_axis_tlast   // last result of an item
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  item_kind_e in_kind_q;
  logic [7:0] in_byte_q;
  logic       accept;
  logic       fire;
  logic       space_ok;

  // Tokenizer state.
  lex_state_t lex_q, lex_next;
  lex_act_t   lex_act;
  held_t      held_q, held_next;
  logic       pend_valid_q;
  result_t    pend_q;
  collect_t   collect;
  out_item_t  head;

  // The registered item is processed as soon as the queue can take its
  // worst-case burst; a new item may enter in the same cycle.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = in_valid_q && space_ok;
  assign s_axis_tready = !in_valid_q || space_ok;
  assign in_valid_d    = accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      lex_q        <= LexReset;
      held_q       <= HeldReset;
      pend_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) begin
        lex_q        <= lex_next;
        held_q       <= held_next;
        pend_valid_q <= collect.pend_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= item_kind_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
    if (fire) begin
      pend_q <= collect.pend;
    end
  end

  // Character classes, lexer modes and byte position.
  kvct_lexer u_lexer (
    .item_kind_i (in_kind_q),
    .item_byte_i (in_byte_q),
    .state_i     (lex_q),
    .state_o     (lex_next),
    .act_o       (lex_act)
  );

  // Three-token window, pair matching and error recovery, and the grouping
  // of this item's results (plus any held-back result) into one burst.
  kvct_parser u_parser (
    .held_i       (held_q),
    .pend_valid_i (pend_valid_q),
    .pend_i       (pend_q),
    .act_i        (lex_act),
    .held_o       (held_next),
    .collect_o    (collect)
  );

  // Result queue: up to four writes per cycle, one read.
  kvct_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (fire),
    .wr_count_i (collect.count),
    .wr_data_i  (collect.res),
    .space_ok_o (space_ok),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (head)
  );

  assign m_axis_tuser = head.res.ev;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = OutDataW'({head.res.bad, head.res.tkind, head.res.text_len,
                                   head.res.text_off, head.res.key_len,
                                   head.res.key_off});

  // A result is only held back when the burst is already full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && collect.pend_valid |-> collect.count == StepCntW'(MaxPerStep))
    else $error("result held back from a burst that is not full");

  // A held-back result always fits into the next item's burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pend_valid_q |-> !collect.pend_valid)
    else $error("held-back result displaced by another");

  // Between items the parser never holds a full window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> held_q.count != 2'd3)
    else $error("parser left three tokens undecided");

  // Content bytes after a close give no results of their own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && lex_q.finished && in_kind_q == KindByte && !pend_valid_q
    |-> collect.count == '0)
    else $error("result produced after the text was closed");

endmodule
